// ----- rtl/tlb_flush_batch_coalescer_assert.svh -----
// Assertion macros for the TLB flush batch coalescer.
// Included by the top level; needs no package and no other file.
`ifndef TLB_FLUSH_BATCH_COALESCER_ASSERT_SVH
`define TLB_FLUSH_BATCH_COALESCER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define TFBC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define TFBC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TFBC_ASSERT(name, clk, rstn, prop, msg)
`define TFBC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- rtl/tfbc_pkg.sv -----
// Shared types and constants of the TLB flush batch coalescer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tfbc_pkg;

  // Sizes of the block.
  localparam int unsigned BatchDepth = 16;
  localparam int unsigned PageBits   = 12;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned TagW       = 6;
  localparam int unsigned CeilW      = 6;
  localparam int unsigned CeilingMax = 32;
  localparam int unsigned CntW       = $clog2(BatchDepth + 1);
  localparam int unsigned IdxW       = (BatchDepth > 1) ? $clog2(BatchDepth) : 1;
  localparam int unsigned SpanW      = AddrW + 1 - PageBits;

  // Result action codes.
  typedef enum logic [1:0] {
    ACT_INVAL  = 2'd0,
    ACT_FLUSH  = 2'd1,
    ACT_ACK    = 2'd2,
    ACT_REJECT = 2'd3
  } action_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REJ,
    ST_DRAIN,
    ST_FLUSH,
    ST_LOAD,
    ST_INVAL,
    ST_ACK
  } state_e;

  // One flush descriptor request.
  typedef struct packed {
    logic [AddrW-1:0] range_start;
    logic [AddrW-1:0] range_end;
    logic [TagW-1:0]  sender_tag;
    logic             batch_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    action_e          action;
    logic [AddrW-1:0] page_address;
    logic [TagW-1:0]  ack_tag;
    logic             run_last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    store;
    logic    eval;
    logic    set_flag;
    logic    clear;
    logic    idx_clr;
    logic    idx_inc;
    logic    va_load;
    logic    va_inc;
    logic    emit;
    action_e act;
    logic    run_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic last;
    logic flag;
    logic slot_free;
    logic va_below;
    logic idx_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/tfbc_ctrl.sv -----
// Controller state machine of the TLB flush batch coalescer.
// Depends on tfbc_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module tfbc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tfbc_pkg::status_t status_i,
  output tfbc_pkg::cmd_t        cmd_o
);

  tfbc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.act  = tfbc_pkg::ACT_INVAL;
    in_ready_o = 1'b0;
    case (state_q)
      tfbc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.full) begin
            state_d = tfbc_pkg::ST_REJ;
          end else begin
            cmd_o.store = 1'b1;
            state_d     = tfbc_pkg::ST_EVAL;
          end
        end
      end
      tfbc_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.last ? tfbc_pkg::ST_DRAIN : tfbc_pkg::ST_IDLE;
      end
      tfbc_pkg::ST_REJ: begin
        if (status_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.act      = tfbc_pkg::ACT_REJECT;
          cmd_o.run_last = !status_i.last;
          if (status_i.last) begin
            cmd_o.set_flag = 1'b1;
            state_d        = tfbc_pkg::ST_DRAIN;
          end else begin
            state_d = tfbc_pkg::ST_IDLE;
          end
        end
      end
      tfbc_pkg::ST_DRAIN: begin
        cmd_o.idx_clr = 1'b1;
        state_d       = status_i.flag ? tfbc_pkg::ST_FLUSH : tfbc_pkg::ST_LOAD;
      end
      tfbc_pkg::ST_FLUSH: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.act  = tfbc_pkg::ACT_FLUSH;
          state_d    = tfbc_pkg::ST_ACK;
        end
      end
      tfbc_pkg::ST_LOAD: begin
        cmd_o.va_load = 1'b1;
        state_d       = tfbc_pkg::ST_INVAL;
      end
      tfbc_pkg::ST_INVAL: begin
        if (!status_i.va_below) begin
          state_d = tfbc_pkg::ST_ACK;
        end else if (status_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.act    = tfbc_pkg::ACT_INVAL;
          cmd_o.va_inc = 1'b1;
        end
      end
      tfbc_pkg::ST_ACK: begin
        if (status_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.act      = tfbc_pkg::ACT_ACK;
          cmd_o.run_last = status_i.idx_last;
          if (status_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = tfbc_pkg::ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = status_i.flag ? tfbc_pkg::ST_ACK : tfbc_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = tfbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tfbc_datapath.sv -----
// Datapath of the TLB flush batch coalescer: descriptor store, page budget,
// page walk and result register. Depends on tfbc_pkg; driven by tfbc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tfbc_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tfbc_pkg::in_item_t            in_item_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [tfbc_pkg::CeilW-1:0]    cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output tfbc_pkg::out_item_t                out_item_o,
  input  wire tfbc_pkg::cmd_t                cmd_i,
  output tfbc_pkg::status_t                  status_o
);

  localparam logic [tfbc_pkg::AddrW:0] PageMask =
    (tfbc_pkg::AddrW + 1)'((64'd1 << tfbc_pkg::PageBits) - 64'd1);
  localparam logic [tfbc_pkg::AddrW:0] PageSize =
    (tfbc_pkg::AddrW + 1)'(64'd1 << tfbc_pkg::PageBits);
  localparam logic [tfbc_pkg::CeilW-1:0] CeilMax = tfbc_pkg::CeilW'(tfbc_pkg::CeilingMax);

  // Descriptor store, written at the fill count and read into registers at
  // the next walk index.
  logic [tfbc_pkg::AddrW-1:0] start_mem [tfbc_pkg::BatchDepth];
  logic [tfbc_pkg::AddrW-1:0] end_mem   [tfbc_pkg::BatchDepth];
  logic [tfbc_pkg::TagW-1:0]  tag_mem   [tfbc_pkg::BatchDepth];

  logic [tfbc_pkg::CntW-1:0]  count_q, count_d;
  logic [tfbc_pkg::CeilW-1:0] total_q, total_d;
  logic                       flag_q, flag_d;
  logic [tfbc_pkg::CeilW-1:0] ceil_q;
  logic [tfbc_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  tfbc_pkg::out_item_t        out_q;
  logic [tfbc_pkg::SpanW-1:0] span_q;
  logic                       bad_q;
  logic [tfbc_pkg::TagW-1:0]  tag_q;
  logic                       last_q;
  logic [tfbc_pkg::AddrW:0]   va_q;

  logic [tfbc_pkg::AddrW:0]   diff;
  logic [tfbc_pkg::CeilW-1:0] ceil_sat, used, room;
  logic [tfbc_pkg::AddrW-1:0] rd_start_q, rd_end_q;
  logic [tfbc_pkg::TagW-1:0]  rd_tag_q;

  // Store write, and the registered read of the entry the walk index moves to.
  // The store is only written while the walk is idle, so the read registers
  // always hold the entry at idx_q once the drain starts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      start_mem[count_q[tfbc_pkg::IdxW-1:0]] <= in_item_i.range_start;
      end_mem[count_q[tfbc_pkg::IdxW-1:0]]   <= in_item_i.range_end;
      tag_mem[count_q[tfbc_pkg::IdxW-1:0]]   <= in_item_i.sender_tag;
    end
    rd_start_q <= start_mem[idx_d];
    rd_end_q   <= end_mem[idx_d];
    rd_tag_q   <= tag_mem[idx_d];
  end

  // Rounded-up page span of the request, registered for the budget check.
  assign diff = {1'b0, in_item_i.range_end} - {1'b0, in_item_i.range_start} + PageMask;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      span_q <= diff[tfbc_pkg::AddrW:tfbc_pkg::PageBits];
      bad_q  <= (in_item_i.range_end == '0) ||
                (in_item_i.range_end <= in_item_i.range_start);
      tag_q  <= in_item_i.sender_tag;
    end
  end

  // Ceiling register; values above the maximum act as the maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q <= CeilMax;
    end else if (cfg_valid_i) begin
      ceil_q <= cfg_data_i;
    end
  end

  assign ceil_sat = (ceil_q > CeilMax) ? CeilMax : ceil_q;
  assign used     = (total_q > ceil_sat) ? ceil_sat : total_q;
  assign room     = ceil_sat - used;

  // Batch bookkeeping: fill count, page budget and full-flush flag.
  always_comb begin
    count_d = count_q;
    total_d = total_q;
    flag_d  = flag_q;
    if (cmd_i.store) begin
      count_d = count_q + tfbc_pkg::CntW'(1);
    end
    if (cmd_i.eval && !flag_q) begin
      if (bad_q || (span_q > tfbc_pkg::SpanW'(room))) begin
        flag_d = 1'b1;
      end else begin
        total_d = total_q + span_q[tfbc_pkg::CeilW-1:0];
      end
    end
    if (cmd_i.set_flag) begin
      flag_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      total_d = '0;
      flag_d  = 1'b0;
    end
  end

  // Walk index.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + tfbc_pkg::IdxW'(1);
    end
  end

  // Control registers of the batch and the result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      flag_q      <= 1'b0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      flag_q      <= flag_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept) begin
        last_q <= in_item_i.batch_last;
      end
    end
  end

  // Page walk address, one page per invalidate result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.va_load) begin
      va_q <= {1'b0, rd_start_q} & ~PageMask;
    end else if (cmd_i.va_inc) begin
      va_q <= va_q + PageSize;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.action   <= cmd_i.act;
      out_q.run_last <= cmd_i.run_last;
      case (cmd_i.act)
        tfbc_pkg::ACT_INVAL: begin
          out_q.page_address <= va_q[tfbc_pkg::AddrW-1:0];
          out_q.ack_tag      <= '0;
        end
        tfbc_pkg::ACT_ACK: begin
          out_q.page_address <= '0;
          out_q.ack_tag      <= rd_tag_q;
        end
        tfbc_pkg::ACT_REJECT: begin
          out_q.page_address <= '0;
          out_q.ack_tag      <= tag_q;
        end
        default: begin
          out_q.page_address <= '0;
          out_q.ack_tag      <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status to the controller.
  assign status_o.full      = (count_q == tfbc_pkg::CntW'(tfbc_pkg::BatchDepth));
  assign status_o.last      = last_q;
  assign status_o.flag      = flag_q;
  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.va_below  = (va_q < {1'b0, rd_end_q});
  assign status_o.idx_last  = ((tfbc_pkg::CntW'(idx_q) + tfbc_pkg::CntW'(1)) == count_q);

endmodule

`default_nettype wire

// ----- rtl/tlb_flush_batch_coalescer.sv -----
// Top level of the TLB flush batch coalescer.
// Depends on tfbc_pkg, tfbc_ctrl, tfbc_datapath and the assertion macro header.
//
// Usage: flush descriptor requests enter on the in channel (valid/ready) as
// in_item_i; results leave on the out channel (valid/ready) as out_item_o.
// The page ceiling is written on the cfg channel, which is always ready.
// A stored descriptor that is not the last one of its batch is accepted, then
// goes through the page-budget check and gives no result. A descriptor that
// finds the store full gives a reject result. After its budget check, or its
// reject result, the last descriptor starts the drain: a set-up state, then
// one result per cycle while the receiver takes them, with a load state and a
// walk-end state for each descriptor in the invalidate form. The controller
// walks the store one entry at a time and the page walker compares each
// address against the range end, one page per invalidate result. Only one
// request is in work at a time; the next is accepted once the current one's
// budget check is done or its last result is in the output register, even
// while that result waits. Reset empties the batch and sets the ceiling to 32.
// When the receiver stalls, the result register holds and the walk waits.
`timescale 1ns / 1ps
`default_nettype none

`include "tlb_flush_batch_coalescer_assert.svh"

module tlb_flush_batch_coalescer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire tfbc_pkg::in_item_t         in_item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output tfbc_pkg::out_item_t             out_item_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tfbc_pkg::CeilW-1:0] cfg_data_i
);

  tfbc_pkg::cmd_t    cmd;
  tfbc_pkg::status_t status;

  // The ceiling register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Controller.
  tfbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  tfbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // Checks on the controller and datapath cooperation.
  `TFBC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "request accepted on two adjacent cycles")
  `TFBC_ASSERT_ALWAYS(a_no_store_when_full, clk_i, !(cmd.store && status.full), "store written while full")
  `TFBC_ASSERT(a_emit_needs_slot, clk_i, rst_ni, cmd.emit |-> status.slot_free, "result emitted over a pending result")
  `TFBC_ASSERT(a_walk_in_range, clk_i, rst_ni, cmd.va_inc |-> (status.va_below && cmd.emit), "page walk stepped past the range end")

endmodule

`default_nettype wire
